@@ src/cfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, character codes and character-class helpers for the
// checksummed frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_EQUAL  = 8'h3D;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_USCORE = 8'h5F;

    localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
    localparam logic [3:0] TYPE_MIN      = 4'd2;
    localparam logic [3:0] TYPE_MAX      = 4'd8;
    localparam logic [3:0] TYPE_SAT      = 4'd9;
    localparam logic [3:0] KEY_MIN       = 4'd1;
    localparam logic [3:0] KEY_MAX       = 4'd12;
    localparam logic [3:0] KEY_SAT       = 4'd13;
    localparam logic [4:0] FIELDS_MAX    = 5'd16;
    localparam logic [4:0] FIELDS_SAT    = 5'd31;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_KEY   = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_CKSUM  = 2'd2
    } t_status;

    typedef logic [2:0][7:0] t_tail;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [4:0]  field_count;
        logic [3:0]  type_length;
        logic [63:0] type_text;
        logic [7:0]  computed_checksum;
    } t_result;

    // Bytes that leave the delay window in one step: up to three held bytes
    // (oldest in entry 0), followed by a run of CR bytes.
    typedef struct packed {
        logic [1:0] cnt;
        t_tail      bytes;
        logic [7:0] run;
    } t_parse_req;

    typedef struct packed {
        logic [7:0] len;
        logic       dollar;
        logic [7:0] xsum;
        t_tail      tail;
    } t_content;

    typedef struct packed {
        t_phase      phase;
        logic [63:0] type_buf;
        logic [3:0]  type_chars;
        logic [3:0]  key_chars;
        logic [4:0]  fields;
        logic        fault;
    } t_field_state;

    function automatic logic is_upper(logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_decode(logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (is_digit(c)) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage
`default_nettype wire

@@ src/cfp_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface cfp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/cfp_content.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_content
// Content tracker: drops trailing CR/LF and everything after a zero byte,
// keeps the running XOR, the content length and a three-byte tail window,
// and issues the bytes that leave the window to the field parser.
// ----------------------------------------------------------------------------
module cfp_content import cfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_parse_req      o_req,
    output t_content        o_next
);

    logic       r_after_zero, n_after_zero;
    logic [7:0] r_crlf_cnt,   n_crlf_cnt;
    logic [7:0] r_crlf_xor,   n_crlf_xor;
    t_tail      r_tail,       n_tail;
    logic [7:0] r_len,        n_len;
    logic       r_dollar,     n_dollar;
    logic [7:0] r_xor,        n_xor;

    logic       w_zero, w_crlf, w_push, w_first, w_app_c;
    logic [1:0] w_old_cnt, w_old_parsed, w_keep;
    logic [7:0] w_run_in;
    logic [8:0] w_total, w_parsed, w_run_parsed;
    logic [9:0] w_len_sum;
    logic [8:0] w_idx [3];
    t_tail      w_tail;

    assign w_zero  = !r_after_zero && (i_byte == 8'h00);
    assign w_crlf  = !r_after_zero && ((i_byte == CHR_CR) || (i_byte == CHR_LF));
    assign w_push  = !r_after_zero && !w_zero && !w_crlf;
    assign w_first = (r_len == 8'd0);

    // Held bytes after the first content byte, left aligned in the window.
    assign w_old_cnt = w_first ? 2'd0 :
                       (r_len >= 8'd4) ? 2'd3 : (r_len[1:0] - 2'd1);

    // A pending CR run that opens the line spends its first byte on slot zero.
    assign w_run_in = (w_first && (r_crlf_cnt != 8'd0)) ? (r_crlf_cnt - 8'd1) : r_crlf_cnt;
    assign w_app_c  = !(w_first && (r_crlf_cnt == 8'd0));

    assign w_total      = {7'd0, w_old_cnt} + {1'b0, w_run_in} + {8'd0, w_app_c};
    assign w_parsed     = (w_total > 9'd3) ? (w_total - 9'd3) : 9'd0;
    assign w_old_parsed = (w_parsed >= {7'd0, w_old_cnt}) ? w_old_cnt : w_parsed[1:0];
    assign w_run_parsed = w_parsed - {7'd0, w_old_parsed};
    assign w_keep       = (w_total >= 9'd3) ? 2'd3 : w_total[1:0];
    assign w_len_sum    = {2'd0, r_len} + {2'd0, r_crlf_cnt} + 10'd1;

    // New window: the last bytes of (held bytes, CR run, current byte).
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_idx[i]  = w_total - {7'd0, w_keep} + 9'(i);
            w_tail[i] = 8'd0;
            if (2'(i) < w_keep) begin
                if (w_idx[i] < {7'd0, w_old_cnt}) begin
                    w_tail[i] = r_tail[w_idx[i][1:0]];
                end else if (w_idx[i] < ({7'd0, w_old_cnt} + {1'b0, w_run_in})) begin
                    w_tail[i] = CHR_CR;
                end else begin
                    w_tail[i] = i_byte;
                end
            end
        end
    end

    always_comb begin
        n_after_zero = r_after_zero;
        n_crlf_cnt   = r_crlf_cnt;
        n_crlf_xor   = r_crlf_xor;
        n_tail       = r_tail;
        n_len        = r_len;
        n_dollar     = r_dollar;
        n_xor        = r_xor;
        if (i_step) begin
            if (w_zero) begin
                n_after_zero = 1'b1;
            end
            if (w_crlf) begin
                if (r_crlf_cnt != 8'hFF) begin
                    n_crlf_cnt = r_crlf_cnt + 8'd1;
                end
                n_crlf_xor = r_crlf_xor ^ i_byte;
            end
            if (w_push) begin
                n_crlf_cnt = 8'd0;
                n_crlf_xor = 8'd0;
                n_tail     = w_tail;
                n_len      = (w_len_sum > 10'd255) ? 8'hFF : w_len_sum[7:0];
                n_xor      = r_xor ^ r_crlf_xor ^ i_byte;
                if (w_first) begin
                    n_dollar = (r_crlf_cnt == 8'd0) && (i_byte == CHR_DOLLAR);
                end
            end
        end
    end

    always_comb begin
        o_req.bytes = r_tail;
        o_req.cnt   = (i_step && w_push) ? w_old_parsed : 2'd0;
        o_req.run   = (i_step && w_push) ? w_run_parsed[7:0] : 8'd0;
    end

    assign o_next = '{len: n_len, dollar: n_dollar, xsum: n_xor, tail: n_tail};

    // Clear everything once the line's result has been formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_after_zero <= 1'b0;
            r_crlf_cnt   <= 8'd0;
            r_crlf_xor   <= 8'd0;
            r_tail       <= '0;
            r_len        <= 8'd0;
            r_dollar     <= 1'b0;
            r_xor        <= 8'd0;
        end else begin
            r_after_zero <= n_after_zero;
            r_crlf_cnt   <= n_crlf_cnt;
            r_crlf_xor   <= n_crlf_xor;
            r_tail       <= n_tail;
            r_len        <= n_len;
            r_dollar     <= n_dollar;
            r_xor        <= n_xor;
        end
    end

    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_len == 8'd0 && r_crlf_cnt == 8'd0 && !r_after_zero))
        else $error("content state not cleared after last byte");

    a_crlf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_crlf_cnt == 8'd0) |-> (r_crlf_xor == 8'd0))
        else $error("pending CR/LF xor without pending bytes");

endmodule
`default_nettype wire

@@ src/cfp_fields.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_fields
// Type and key=value parser: consumes up to three window bytes and a run
// of CR bytes per step, and tracks type text, counts and format faults.
// ----------------------------------------------------------------------------
module cfp_fields import cfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_last,
    input  wire t_parse_req i_req,
    output t_field_state    o_next
);

    t_field_state r_state, n_state;
    t_field_state w_s1, w_s2, w_s3;

    function automatic t_field_state open_segment(t_field_state s);
        t_field_state r;
        r = s;
        if (s.fields >= FIELDS_MAX) begin
            r.fault = 1'b1;
        end
        r.key_chars = 4'd0;
        r.phase     = PH_KEY;
        return r;
    endfunction

    function automatic t_field_state parse_char(t_field_state s, logic [7:0] c);
        t_field_state r;
        r = s;
        case (s.phase)
            PH_TYPE: begin
                if (c == CHR_COMMA) begin
                    if ((s.type_chars < TYPE_MIN) || (s.type_chars > TYPE_MAX)) begin
                        r.fault = 1'b1;
                    end
                    r = open_segment(r);
                end else begin
                    if (!is_upper(c)) begin
                        r.fault = 1'b1;
                    end
                    if (s.type_chars < TYPE_MAX) begin
                        r.type_buf[{s.type_chars[2:0], 3'b000} +: 8] =
                            s.type_buf[{s.type_chars[2:0], 3'b000} +: 8] | c;
                    end
                    if (s.type_chars < TYPE_SAT) begin
                        r.type_chars = s.type_chars + 4'd1;
                    end
                end
            end
            PH_KEY: begin
                if (c == CHR_COMMA) begin
                    r.fault = 1'b1;
                    r = open_segment(r);
                end else if (c == CHR_EQUAL) begin
                    if ((s.key_chars < KEY_MIN) || (s.key_chars > KEY_MAX)) begin
                        r.fault = 1'b1;
                    end
                    if (s.fields < FIELDS_SAT) begin
                        r.fields = s.fields + 5'd1;
                    end
                    r.phase = PH_VALUE;
                end else begin
                    if (s.key_chars == 4'd0) begin
                        if (!is_lower(c)) begin
                            r.fault = 1'b1;
                        end
                    end else if (!(is_lower(c) || is_digit(c) || (c == CHR_USCORE))) begin
                        r.fault = 1'b1;
                    end
                    if (s.key_chars < KEY_SAT) begin
                        r.key_chars = s.key_chars + 4'd1;
                    end
                end
            end
            default: begin
                if (c == CHR_COMMA) begin
                    r = open_segment(r);
                end
            end
        endcase
        return r;
    endfunction

    // A run of CR bytes: a fault in type or key, padding of the type text.
    function automatic t_field_state apply_run(t_field_state s, logic [7:0] k);
        t_field_state r;
        logic [8:0]   tsum;
        logic [8:0]   ksum;
        r    = s;
        tsum = {5'd0, s.type_chars} + {1'b0, k};
        ksum = {5'd0, s.key_chars} + {1'b0, k};
        if (k != 8'd0) begin
            case (s.phase)
                PH_TYPE: begin
                    r.fault = 1'b1;
                    for (int p = 0; p < 8; p++) begin
                        if ((9'(p) >= {5'd0, s.type_chars}) && (9'(p) < tsum)) begin
                            r.type_buf[8*p +: 8] = s.type_buf[8*p +: 8] | CHR_CR;
                        end
                    end
                    r.type_chars = (tsum > {5'd0, TYPE_SAT}) ? TYPE_SAT : tsum[3:0];
                end
                PH_KEY: begin
                    r.fault     = 1'b1;
                    r.key_chars = (ksum > {5'd0, KEY_SAT}) ? KEY_SAT : ksum[3:0];
                end
                default: begin
                    r = s;
                end
            endcase
        end
        return r;
    endfunction

    always_comb begin
        w_s1    = (i_req.cnt >= 2'd1) ? parse_char(r_state, i_req.bytes[0]) : r_state;
        w_s2    = (i_req.cnt >= 2'd2) ? parse_char(w_s1, i_req.bytes[1]) : w_s1;
        w_s3    = (i_req.cnt == 2'd3) ? parse_char(w_s2, i_req.bytes[2]) : w_s2;
        n_state = apply_run(w_s3, i_req.run);
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    a_value_has_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_VALUE) |-> (r_state.fields != 5'd0))
        else $error("value phase without a counted field");

endmodule
`default_nettype wire

@@ src/cfp_verdict.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_verdict
// End-of-line check: frame shape, checksum compare and format status,
// in that priority, giving the result item for the line.
// ----------------------------------------------------------------------------
module cfp_verdict import cfp_pkg::*; (
    input  wire t_content     i_content,
    input  wire t_field_state i_fields,
    output t_result           o_result
);

    logic       w_shape, w_bad;
    logic [4:0] w_hi, w_lo;
    logic [7:0] w_sum;

    assign w_hi    = hex_decode(i_content.tail[1]);
    assign w_lo    = hex_decode(i_content.tail[2]);
    assign w_shape = (i_content.len >= MIN_FRAME_LEN) && i_content.dollar &&
                     (i_content.tail[0] == CHR_STAR);
    assign w_sum   = i_content.xsum ^ CHR_DOLLAR ^ i_content.tail[0] ^
                     i_content.tail[1] ^ i_content.tail[2];
    assign w_bad   = i_fields.fault ||
                     ((i_fields.phase == PH_TYPE) &&
                      ((i_fields.type_chars < TYPE_MIN) || (i_fields.type_chars > TYPE_MAX))) ||
                     (i_fields.phase == PH_KEY);

    always_comb begin
        o_result = '{status: ST_FORMAT, field_count: 5'd0, type_length: 4'd0,
                     type_text: 64'd0, computed_checksum: 8'd0};
        if (w_shape && w_hi[4] && w_lo[4]) begin
            o_result.computed_checksum = w_sum;
            if (w_sum != {w_hi[3:0], w_lo[3:0]}) begin
                o_result.status = ST_CKSUM;
            end else if (!w_bad) begin
                o_result.status      = ST_OK;
                o_result.field_count = i_fields.fields;
                o_result.type_length = i_fields.type_chars;
                o_result.type_text   = i_fields.type_buf;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/checksummed_frame_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_parser
// Streaming parser for $TYPE,key=value,...*HH lines with an XOR checksum.
// ----------------------------------------------------------------------------
// Takes one line byte per request, one request per clock, with no gaps
// needed between bytes or between lines. Each byte is held in an input
// register and fully processed as it leaves that register (CR/LF filtering,
// three-byte tail window, type/key parsing). The byte marked last also forms
// the line's result. That result is registered as the byte leaves the input
// register and is then shown on o_result from the output register. A single
// result register sits on the output: the parser keeps taking bytes while a
// result waits, and stalls only when a further last byte arrives before the
// waiting result has been taken.
module checksummed_frame_parser import cfp_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    cfp_stream_if.sink   i_frame,
    cfp_stream_if.source o_result
);

    logic         r_in_valid;
    t_in_item     r_in;
    logic         r_out_valid;
    t_result      r_out;

    logic         w_advance;
    t_parse_req   w_req;
    t_content     w_content;
    t_field_state w_fields;
    t_result      w_result;

    // Hold a last byte while the previous result is still waiting.
    assign w_advance     = r_in_valid && (!r_in.last_byte || !r_out_valid || o_result.ready);
    assign i_frame.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_in <= i_frame.payload;
        end
    end

    cfp_content u_content (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in.byte_value),
        .i_last  (r_in.last_byte),
        .o_req   (w_req),
        .o_next  (w_content)
    );

    cfp_fields u_fields (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_last  (r_in.last_byte),
        .i_req   (w_req),
        .o_next  (w_fields)
    );

    cfp_verdict u_verdict (
        .i_content (w_content),
        .i_fields  (w_fields),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_byte) |-> (!r_out_valid || o_result.ready))
        else $error("result register overwritten before it was taken");

    a_ok_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_byte && w_result.status == ST_OK) |->
        (w_result.type_length >= TYPE_MIN && w_result.type_length <= TYPE_MAX &&
         w_result.field_count <= FIELDS_MAX))
        else $error("accepted line with out-of-range type or field count");

    a_fail_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_byte && w_result.status != ST_OK) |->
        (w_result.field_count == 5'd0 && w_result.type_length == 4'd0 &&
         w_result.type_text == 64'd0))
        else $error("failed line reports type or fields");

endmodule
`default_nettype wire

@@ tb/checksummed_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_parser_tb
// Feeds $TYPE,key=value,...*HH lines byte by byte: a directed set of edge
// cases, then random sentences, some of them damaged, plus noise lines. A
// parser model scores every accepted byte and queues the line result; each
// result taken from the block is checked field by field against that queue.
// ----------------------------------------------------------------------------
module checksummed_frame_parser_tb;
    import cfp_pkg::*;

    localparam logic [7:0] NUL         = 8'h00;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_BYTES = 1020;

    typedef logic [7:0] t_line [$];

    typedef struct {
        t_in_item item;
        bit       drain;  // hold this request until no result is outstanding
    } t_feed;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cfp_stream_if #(.T(t_in_item)) frame_if ();
    cfp_stream_if #(.T(t_result))  result_if ();

    checksummed_frame_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .o_result (result_if)
    );

    always #5 i_clk = ~i_clk;

    t_feed   byte_feed [$];
    t_result frame_results_due [$];

    int  n_accepted = 0;
    int  n_checked  = 0;
    int  n_errors   = 0;
    int  n_cycles   = 0;
    int  n_ok = 0, n_fmt = 0, n_cksum = 0;
    logic calm;

    // No idling on either side over this stretch of the byte stream.
    assign calm = (n_accepted >= 1100) && (n_accepted < 1600);

    // ------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------
    t_phase      cur_phase;
    logic [7:0]  line_xor;
    logic [7:0]  crlf_run;
    logic [7:0]  crlf_run_xor;
    logic [7:0]  tail_bytes [0:2];
    logic [7:0]  body_len;
    logic [63:0] type_acc;
    logic [3:0]  type_len_cnt;
    logic [3:0]  key_len_cnt;
    logic [4:0]  field_total;
    logic        fmt_bad;
    logic        zero_hit;
    logic        first_is_dollar;

    function automatic void clear_line_state();
        cur_phase       = PH_TYPE;
        line_xor        = 8'h00;
        crlf_run        = 8'h00;
        crlf_run_xor    = 8'h00;
        tail_bytes[0]   = 8'h00;
        tail_bytes[1]   = 8'h00;
        tail_bytes[2]   = 8'h00;
        body_len        = 8'h00;
        type_acc        = 64'h0;
        type_len_cnt    = 4'd0;
        key_len_cnt     = 4'd0;
        field_total     = 5'd0;
        fmt_bad         = 1'b0;
        zero_hit        = 1'b0;
        first_is_dollar = 1'b0;
    endfunction

    function automatic void open_field();
        if (field_total >= FIELDS_MAX) fmt_bad = 1'b1;
        key_len_cnt = 4'd0;
        cur_phase   = PH_KEY;
    endfunction

    function automatic logic lower_ch(logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic digit_ch(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Byte of the region between the leading '$' and the closing *HH.
    function automatic void scan_field_char(logic [7:0] c);
        case (cur_phase)
            PH_TYPE: begin
                if (c == CHR_COMMA) begin
                    if (type_len_cnt < TYPE_MIN || type_len_cnt > TYPE_MAX) fmt_bad = 1'b1;
                    open_field();
                end else begin
                    if (!(c >= 8'h41 && c <= 8'h5A)) fmt_bad = 1'b1;
                    if (type_len_cnt < TYPE_MAX)
                        type_acc[8 * int'(type_len_cnt) +: 8] = c;
                    if (type_len_cnt < TYPE_SAT) type_len_cnt++;
                end
            end
            PH_KEY: begin
                if (c == CHR_COMMA) begin
                    fmt_bad = 1'b1;
                    open_field();
                end else if (c == CHR_EQUAL) begin
                    if (key_len_cnt < KEY_MIN || key_len_cnt > KEY_MAX) fmt_bad = 1'b1;
                    if (field_total < FIELDS_SAT) field_total++;
                    cur_phase = PH_VALUE;
                end else begin
                    if (key_len_cnt == 4'd0) begin
                        if (!lower_ch(c)) fmt_bad = 1'b1;
                    end else if (!(lower_ch(c) || digit_ch(c) || c == CHR_USCORE)) begin
                        fmt_bad = 1'b1;
                    end
                    if (key_len_cnt < KEY_SAT) key_len_cnt++;
                end
            end
            default: begin
                if (c == CHR_COMMA) open_field();
            end
        endcase
    endfunction

    // Content passes a three-byte delay so that *HH never reaches the fields.
    function automatic void shift_in_content(logic [7:0] c);
        if (body_len == 8'd0) begin
            first_is_dollar = (c == CHR_DOLLAR);
        end else if (body_len < 8'd4) begin
            tail_bytes[body_len - 8'd1] = c;
        end else begin
            scan_field_char(tail_bytes[0]);
            tail_bytes[0] = tail_bytes[1];
            tail_bytes[1] = tail_bytes[2];
            tail_bytes[2] = c;
        end
        if (body_len != 8'hFF) body_len++;
    endfunction

    // {valid, value}
    function automatic logic [4:0] nibble_of(logic [7:0] c);
        if (digit_ch(c)) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        return 5'd0;
    endfunction

    function automatic void take_line_byte(t_in_item it);
        logic [7:0] c;
        t_result    r;
        logic [3:0] hi, lo;
        logic       hi_ok, lo_ok, shape, bad;
        logic [7:0] sum;
        c = it.byte_value;
        if (!zero_hit) begin
            if (c == NUL) begin
                zero_hit = 1'b1;
            end else if (c == CHR_CR || c == CHR_LF) begin
                if (crlf_run != 8'hFF) crlf_run++;
                crlf_run_xor ^= c;
            end else begin
                // A line-end run followed by more content is content after all.
                for (int k = 0; k < crlf_run; k++) shift_in_content(CHR_CR);
                line_xor ^= crlf_run_xor;
                crlf_run = 8'h00;
                crlf_run_xor = 8'h00;
                shift_in_content(c);
                line_xor ^= c;
            end
        end
        if (!it.last_byte) return;

        r = '0;
        r.status = ST_FORMAT;
        shape = (body_len >= MIN_FRAME_LEN) && first_is_dollar && (tail_bytes[0] == CHR_STAR);
        {hi_ok, hi} = nibble_of(tail_bytes[1]);
        {lo_ok, lo} = nibble_of(tail_bytes[2]);
        if (shape && hi_ok && lo_ok) begin
            sum = line_xor ^ CHR_DOLLAR ^ tail_bytes[0] ^ tail_bytes[1] ^ tail_bytes[2];
            r.computed_checksum = sum;
            if (sum != {hi, lo}) begin
                r.status = ST_CKSUM;
            end else begin
                bad = fmt_bad || (cur_phase == PH_KEY) ||
                      (cur_phase == PH_TYPE &&
                       (type_len_cnt < TYPE_MIN || type_len_cnt > TYPE_MAX));
                if (!bad) begin
                    r.status      = ST_OK;
                    r.field_count = field_total;
                    r.type_length = type_len_cnt;
                    r.type_text   = type_acc;
                end
            end
        end
        frame_results_due.push_back(r);
        clear_line_state();
    endfunction

    // ------------------------------------------------------------------
    // Line building
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower_hex);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (lower_hex ? 8'h57 : 8'h37) + 8'(n);
    endfunction

    function automatic void put_text(inout t_line ln, input string s);
        for (int k = 0; k < s.len(); k++) ln.push_back(s[k]);
    endfunction

    // Close a line that starts with '$' with *HH over everything after it.
    function automatic void seal(inout t_line ln, input bit lower_hex);
        logic [7:0] x;
        x = 8'h00;
        for (int k = 1; k < ln.size(); k++) x ^= ln[k];
        ln.push_back(CHR_STAR);
        ln.push_back(hex_char(x[7:4], lower_hex));
        ln.push_back(hex_char(x[3:0], lower_hex));
    endfunction

    function automatic void queue_line(t_line ln, bit drain);
        t_feed f;
        for (int k = 0; k < ln.size(); k++) begin
            f.item.byte_value = ln[k];
            f.item.last_byte  = (k == ln.size() - 1);
            f.drain           = drain && (k == 0);
            byte_feed.push_back(f);
        end
    endfunction

    function automatic void queue_sealed(string s);
        t_line ln;
        put_text(ln, s);
        seal(ln, 1'b0);
        queue_line(ln, 1'b0);
    endfunction

    function automatic logic [7:0] rnd_upper();
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rnd_lower();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rnd_key_char();
        int r;
        r = $urandom_range(0, 37);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 36) return 8'h30 + 8'(r - 26);
        return CHR_USCORE;
    endfunction

    function automatic logic [7:0] rnd_value_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 3) return r[0] ? CHR_CR : CHR_LF;
        if (r < 6) return 8'($urandom_range(128, 255));
        c = 8'($urandom_range(32, 126));
        return (c == CHR_COMMA) ? 8'h2E : c;
    endfunction

    function automatic void make_sentence(inout t_line ln);
        int tlen, nf, klen, pos;
        ln.push_back(CHR_DOLLAR);
        if ($urandom_range(0, 99) < 6)
            tlen = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(9, 10);
        else
            tlen = $urandom_range(2, 8);
        for (int k = 0; k < tlen; k++)
            ln.push_back(($urandom_range(0, 99) < 3) ? rnd_key_char() : rnd_upper());
        nf = ($urandom_range(0, 99) < 10) ? $urandom_range(14, 17) : $urandom_range(0, 4);
        for (int f = 0; f < nf; f++) begin
            ln.push_back(CHR_COMMA);
            if ($urandom_range(0, 99) < 5)
                klen = $urandom_range(0, 1) ? 0 : $urandom_range(13, 14);
            else
                klen = $urandom_range(1, 12);
            for (int k = 0; k < klen; k++) begin
                if ($urandom_range(0, 99) < 3)
                    ln.push_back(rnd_upper());
                else if (k == 0)
                    ln.push_back(($urandom_range(0, 99) < 4) ? rnd_key_char() : rnd_lower());
                else
                    ln.push_back(rnd_key_char());
            end
            // now and then leave the '=' out of a segment
            if ($urandom_range(0, 99) >= 2) begin
                ln.push_back(CHR_EQUAL);
                repeat ($urandom_range(0, 6)) ln.push_back(rnd_value_char());
            end
        end
        if ($urandom_range(0, 99) < 3) ln.push_back(CHR_COMMA);
        seal(ln, 1'($urandom_range(0, 1)));

        if ($urandom_range(0, 99) < 12) begin
            pos = $urandom_range(0, ln.size() - 1);
            case ($urandom_range(0, 4))
                0: ln[ln.size() - 2] = (ln[ln.size() - 2] == 8'h30) ? 8'h31 : 8'h30;
                1: ln[pos] = 8'($urandom_range(0, 255));
                2: ln[0] = $urandom_range(0, 1) ? rnd_upper() : 8'h20;
                3: ln.insert(pos, NUL);
                default: begin
                    while (ln.size() > pos + 1) void'(ln.pop_back());
                end
            endcase
        end
        repeat ($urandom_range(0, 2)) ln.push_back($urandom_range(0, 1) ? CHR_CR : CHR_LF);
    endfunction

    task automatic note_error(string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: scores each accepted byte, then offers the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.valid <= 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                take_line_byte(frame_if.payload);
                n_accepted++;
            end
            if (!frame_if.valid || frame_if.ready) begin
                if (byte_feed.size() != 0 &&
                    !(byte_feed[0].drain && frame_results_due.size() != 0) &&
                    (calm || $urandom_range(0, 99) >= 11)) begin
                    frame_if.payload <= byte_feed[0].item;
                    frame_if.valid   <= 1'b1;
                    void'(byte_feed.pop_front());
                end else begin
                    frame_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                got = result_if.payload;
                if (frame_results_due.size() == 0) begin
                    note_error($sformatf("result %0d arrived with none pending", n_checked));
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.status !== want.status)
                        note_error($sformatf("result %0d status got %0d want %0d",
                                             n_checked, got.status, want.status));
                    if (got.field_count !== want.field_count)
                        note_error($sformatf("result %0d field_count got %0d want %0d",
                                             n_checked, got.field_count, want.field_count));
                    if (got.type_length !== want.type_length)
                        note_error($sformatf("result %0d type_length got %0d want %0d",
                                             n_checked, got.type_length, want.type_length));
                    if (got.type_text !== want.type_text)
                        note_error($sformatf("result %0d type_text got %h want %h",
                                             n_checked, got.type_text, want.type_text));
                    if (got.computed_checksum !== want.computed_checksum)
                        note_error($sformatf("result %0d checksum got %h want %h", n_checked,
                                             got.computed_checksum, want.computed_checksum));
                end
                case (got.status)
                    ST_OK:     n_ok++;
                    ST_CKSUM:  n_cksum++;
                    default:   n_fmt++;
                endcase
                n_checked++;
            end
            result_if.ready <= calm || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("ERROR: run timed out with %0d results outstanding",
                     frame_results_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        t_line ln;
        int    sent;
        int    pick;
        bit    first;

        frame_if.valid   = 1'b0;
        frame_if.payload = '0;
        result_if.ready  = 1'b0;
        clear_line_state();

        // Directed lines
        queue_sealed("$GP");
        ln.delete();
        put_text(ln, "$ABCDEFGH,abcdefghi_09=x");
        for (int f = 1; f < 16; f++) put_text(ln, ",z9=v");
        seal(ln, 1'b1);
        queue_line(ln, 1'b0);
        ln.delete();
        put_text(ln, "$XY");
        repeat (17) put_text(ln, ",a=1");
        seal(ln, 1'b0);
        queue_line(ln, 1'b0);
        queue_sealed("$ABCDEFGHI,a=1");
        queue_sealed("$A,a=1");
        queue_sealed("$GPa,b=2");
        // wrong checksum digit
        ln.delete();
        put_text(ln, "$GP,a=1");
        seal(ln, 1'b0);
        ln[ln.size() - 1] = (ln[ln.size() - 1] == 8'h30) ? 8'h31 : 8'h30;
        queue_line(ln, 1'b0);
        // CR/LF inside the content and at the end
        ln.delete();
        put_text(ln, "$GP,t=1");
        ln.push_back(CHR_CR);
        ln.push_back(CHR_LF);
        put_text(ln, "2");
        seal(ln, 1'b0);
        ln.push_back(CHR_CR);
        ln.push_back(CHR_LF);
        queue_line(ln, 1'b0);
        // zero byte ends the content, junk follows
        ln.delete();
        put_text(ln, "$GP,a=1");
        seal(ln, 1'b1);
        ln.push_back(NUL);
        put_text(ln, "x*Z");
        queue_line(ln, 1'b0);
        // empty lines
        ln.delete();
        ln.push_back(CHR_CR);
        ln.push_back(CHR_LF);
        queue_line(ln, 1'b0);
        ln.delete();
        ln.push_back(NUL);
        queue_line(ln, 1'b0);
        ln.delete();
        put_text(ln, "$*00");
        queue_line(ln, 1'b0);
        queue_sealed("$GP,a=1,");
        queue_sealed("$GP,=1");
        queue_sealed("$GP,1a=1");
        queue_sealed("$GP,abc");
        queue_sealed("$GP,abcdefghijklm=1");
        // long runs saturate the counters
        ln.delete();
        put_text(ln, "$GP,a=");
        repeat (260) ln.push_back(CHR_CR);
        put_text(ln, "x");
        seal(ln, 1'b0);
        queue_line(ln, 1'b1);
        ln.delete();
        put_text(ln, "$GP,a=");
        repeat (260) ln.push_back(8'h76);
        seal(ln, 1'b0);
        queue_line(ln, 1'b0);
        ln.delete();
        put_text(ln, "$GP,a=");
        ln.push_back(8'hFF);
        ln.push_back(8'h80);
        seal(ln, 1'b1);
        queue_line(ln, 1'b0);

        // Random lines: mostly sentences, some noise and bare line ends
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_BYTES) begin
            ln.delete();
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                repeat ($urandom_range(1, 20)) ln.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 6) begin
                repeat ($urandom_range(1, 3))
                    ln.push_back($urandom_range(0, 2) == 0 ? NUL :
                                 ($urandom_range(0, 1) ? CHR_CR : CHR_LF));
            end else begin
                make_sentence(ln);
            end
            queue_line(ln, first || ($urandom_range(0, 99) < 2));
            first = 1'b0;
            sent += ln.size();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed.size() != 0 || frame_if.valid) @(posedge i_clk);
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("tb: %0d bytes accepted, %0d line results checked", n_accepted, n_checked);
        $display("tb: results by status: %0d ok, %0d format error, %0d checksum error",
                 n_ok, n_fmt, n_cksum);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ checksummed_frame_parser.f @@
src/cfp_pkg.sv
src/cfp_stream_if.sv
src/cfp_content.sv
src/cfp_fields.sv
src/cfp_verdict.sv
src/checksummed_frame_parser.sv
tb/checksummed_frame_parser_tb.sv
